// ===== rtl/pne_pkg.sv =====
// pne_pkg: widths, latencies and shared types of the palm normal estimator
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package pne_pkg;

  localparam int NormalFracBits = 14;

  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  localparam int MagW   = CrossW - 1;
  localparam int PosW   = 6;
  localparam int NormW  = 30;
  localparam int SqW    = 2 * NormW;
  localparam int SumW   = SqW + 2;
  localparam int RootW  = SumW / 2;
  localparam int QuotW  = NormalFracBits + 2;
  localparam int DvW    = NormW + NormalFracBits + 1;
  localparam int OutW   = 16;
  localparam int ExtW   = (QuotW > OutW + 1) ? QuotW : OutW + 1;

  localparam int FrontLat = 7;
  localparam int SqrtLat  = RootW + 1;
  localparam int DivLat   = QuotW + 1;

  typedef logic [2:0][NormW-1:0] norm3_t;
  typedef logic [2:0][QuotW-1:0] quot3_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       right;
    logic       deg;
  } side_t;

endpackage

// ===== rtl/pne_sqrt.sv =====
// pne_sqrt: pipelined integer square root, one root bit per stage
// depends on pne_pkg; the sum of the three squares is registered first, then the root bits follow
`timescale 1ns / 1ps

module pne_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [2:0][pne_pkg::SqW-1:0] sq_i,
  output logic [pne_pkg::RootW-1:0]   root_o
);
  import pne_pkg::*;

  logic [SumW-1:0]  rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= SumW'(sq_i[0]) + SumW'(sq_i[1]) + SumW'(sq_i[2]);
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < RootW; j++) begin : g_step
    localparam int Bit = RootW - 1 - j;
    logic [SumW+1:0] trial;
    logic            take;

    always_comb begin
      trial = ((SumW + 2)'(root_q[j]) << (Bit + 1)) | ((SumW + 2)'(1) << (2 * Bit));
      take  = (SumW + 2)'(rem_q[j]) >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= take ? SumW'((SumW + 2)'(rem_q[j]) - trial) : rem_q[j];
        root_q[j+1] <= take ? (root_q[j] | (RootW'(1) << Bit)) : root_q[j];
      end
    end
  end

  assign root_o = root_q[RootW];

endmodule

// ===== rtl/pne_div.sv =====
// pne_div: pipelined rounded division of three magnitudes by the norm
// depends on pne_pkg; restoring division, one quotient bit per stage
`timescale 1ns / 1ps

module pne_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pne_pkg::RootW-1:0] n_i,
  input  pne_pkg::norm3_t           mag_i,
  output pne_pkg::quot3_t           q_o
);
  import pne_pkg::*;

  logic [RootW-1:0]          n_q   [QuotW+1];
  logic [2:0][RootW-1:0]     rem_q [QuotW+1];
  logic [2:0][QuotW-1:0]     low_q [QuotW+1];
  logic [2:0][QuotW-1:0]     quo_q [QuotW+1];
  logic [2:0][DvW-1:0]       dvd;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvd[k] = (DvW'(mag_i[k]) << NormalFracBits) + DvW'(n_i >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= n_i;
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= RootW'(dvd[k] >> QuotW);
        low_q[0][k] <= dvd[k][QuotW-1:0];
        quo_q[0][k] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QuotW; j++) begin : g_step
    logic [2:0][RootW:0] part;
    logic [2:0]          take;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        part[k] = {rem_q[j][k], low_q[j][k][QuotW-1-j]};
        take[k] = part[k] >= {1'b0, n_q[j]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1]   <= n_q[j];
        low_q[j+1] <= low_q[j];
        for (int k = 0; k < 3; k++) begin
          rem_q[j+1][k] <= take[k] ? RootW'(part[k] - {1'b0, n_q[j]}) : RootW'(part[k]);
          quo_q[j+1][k] <= {quo_q[j][k][QuotW-2:0], take[k]};
        end
      end
    end
  end

  assign q_o = quo_q[QuotW];

endmodule

// ===== rtl/palm_normal_estimator_unit.sv =====
// palm_normal_estimator_unit: unit palm normal from wrist, index and pinky landmarks
// depends on pne_pkg, pne_sqrt and pne_div
// Fully pipelined: one item accepted per clock while no stall holds the
// pipeline. Stages: 7 front stages for differences, cross product,
// magnitude, leading-one search, shift and squares; 32 square root
// stages, the sum of squares and then one root bit each; 17 divider
// stages, setup and then one quotient bit each; one output register.
// A stall on a valid output freezes the whole pipeline and holds
// in_stall_o high.
`timescale 1ns / 1ps

module palm_normal_estimator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pne_pkg::CoordW-1:0]  wrist_x_i,
  input  logic signed [pne_pkg::CoordW-1:0]  wrist_y_i,
  input  logic signed [pne_pkg::CoordW-1:0]  wrist_z_i,
  input  logic signed [pne_pkg::CoordW-1:0]  index_base_x_i,
  input  logic signed [pne_pkg::CoordW-1:0]  index_base_y_i,
  input  logic signed [pne_pkg::CoordW-1:0]  index_base_z_i,
  input  logic signed [pne_pkg::CoordW-1:0]  pinky_base_x_i,
  input  logic signed [pne_pkg::CoordW-1:0]  pinky_base_y_i,
  input  logic signed [pne_pkg::CoordW-1:0]  pinky_base_z_i,
  input  logic                               is_right_hand_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pne_pkg::OutW-1:0]    normal_x_o,
  output logic signed [pne_pkg::OutW-1:0]    normal_y_o,
  output logic signed [pne_pkg::OutW-1:0]    normal_z_o,
  output logic                               degenerate_o
);
  import pne_pkg::*;

  logic en;

  logic [FrontLat:1]          v_q;
  logic [SqrtLat-1:0]         vsq_q;
  logic [DivLat-1:0]          vdv_q;
  logic                       out_valid_q;

  logic signed [DiffW-1:0]    ex_q [3];
  logic signed [DiffW-1:0]    dx_q [3];
  logic signed [ProdW-1:0]    p_q  [6];
  logic signed [CrossW-1:0]   c_q  [3];
  logic [2:0][MagW-1:0]       mag_q;
  logic [2:0][MagW-1:0]       mag5_q;
  logic [MagW-1:0]            mag_or;
  logic [PosW-1:0]            pos_d;
  logic [PosW-1:0]            pos_q;
  norm3_t                     nm_q;
  norm3_t                     nm7_q;
  logic [2:0][SqW-1:0]        sq_q;
  norm3_t                     nmd_q [SqrtLat];
  logic [3:1]                 right_q;
  logic [2:0]                 neg4_q;
  logic                       right4_q;
  side_t                      side5_q;
  side_t                      side6_q;
  side_t                      side7_q;
  side_t                      ssq_q [SqrtLat];
  side_t                      sdv_q [DivLat];
  logic [RootW-1:0]           root;
  quot3_t                     quo;
  logic [2:0][OutW-1:0]       res_d;
  logic [OutW-1:0]            nx_q, ny_q, nz_q;
  logic                       deg_q;

  logic signed [CoordW-1:0]   w_s [3];
  logic signed [CoordW-1:0]   i_s [3];
  logic signed [CoordW-1:0]   k_s [3];

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  assign w_s[0] = wrist_x_i;      assign w_s[1] = wrist_y_i;      assign w_s[2] = wrist_z_i;
  assign i_s[0] = index_base_x_i; assign i_s[1] = index_base_y_i; assign i_s[2] = index_base_z_i;
  assign k_s[0] = pinky_base_x_i; assign k_s[1] = pinky_base_y_i; assign k_s[2] = pinky_base_z_i;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      vsq_q       <= '0;
      vdv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[FrontLat-1:1], in_valid_i};
      vsq_q       <= {vsq_q[SqrtLat-2:0], v_q[FrontLat]};
      vdv_q       <= {vdv_q[DivLat-2:0], vsq_q[SqrtLat-1]};
      out_valid_q <= vdv_q[DivLat-1];
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    mag_or = mag_q[0] | mag_q[1] | mag_q[2];
    pos_d  = '0;
    for (int b = 0; b < MagW; b++) begin
      if (mag_or[b]) begin
        pos_d = PosW'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ex_q[k] <= DiffW'(i_s[k]) - DiffW'(w_s[k]);
        dx_q[k] <= DiffW'(k_s[k]) - DiffW'(w_s[k]);
      end
      right_q[1] <= is_right_hand_i;

      p_q[0] <= dx_q[1] * ex_q[2];
      p_q[1] <= dx_q[2] * ex_q[1];
      p_q[2] <= dx_q[2] * ex_q[0];
      p_q[3] <= dx_q[0] * ex_q[2];
      p_q[4] <= dx_q[0] * ex_q[1];
      p_q[5] <= dx_q[1] * ex_q[0];
      right_q[2] <= right_q[1];

      for (int k = 0; k < 3; k++) begin
        c_q[k] <= CrossW'(p_q[2*k]) - CrossW'(p_q[2*k+1]);
      end
      right_q[3] <= right_q[2];

      for (int k = 0; k < 3; k++) begin
        neg4_q[k] <= c_q[k][CrossW-1];
        mag_q[k]  <= MagW'(c_q[k][CrossW-1] ? -c_q[k] : c_q[k]);
      end
      right4_q <= right_q[3];

      mag5_q        <= mag_q;
      pos_q         <= pos_d;
      side5_q.neg   <= neg4_q;
      side5_q.right <= right4_q;
      side5_q.deg   <= (mag_q[0] | mag_q[1] | mag_q[2]) == '0;

      for (int k = 0; k < 3; k++) begin
        if (pos_q >= PosW'(NormW - 1)) begin
          nm_q[k] <= NormW'(mag5_q[k] >> (pos_q - PosW'(NormW - 1)));
        end else begin
          nm_q[k] <= NormW'(mag5_q[k] << (PosW'(NormW - 1) - pos_q));
        end
      end
      side6_q <= side5_q;

      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= nm_q[k] * nm_q[k];
      end
      nm7_q   <= nm_q;
      side7_q <= side6_q;

      nmd_q[0] <= nm7_q;
      ssq_q[0] <= side7_q;
      for (int s = 1; s < SqrtLat; s++) begin
        nmd_q[s] <= nmd_q[s-1];
        ssq_q[s] <= ssq_q[s-1];
      end

      sdv_q[0] <= ssq_q[SqrtLat-1];
      for (int s = 1; s < DivLat; s++) begin
        sdv_q[s] <= sdv_q[s-1];
      end

      nx_q  <= res_d[0];
      ny_q  <= res_d[1];
      nz_q  <= res_d[2];
      deg_q <= sdv_q[DivLat-1].deg;
    end
  end

  pne_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (sq_q),
    .root_o (root)
  );

  pne_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (root),
    .mag_i (nmd_q[SqrtLat-1]),
    .q_o   (quo)
  );

  // saturate, apply sign, zero for a degenerate item
  always_comb begin
    logic [ExtW-1:0] qx;
    logic            sg;
    for (int k = 0; k < 3; k++) begin
      qx = ExtW'(quo[k]);
      if (qx > ExtW'(32768)) begin
        qx = ExtW'(32768);
      end
      sg = sdv_q[DivLat-1].neg[k] ^ sdv_q[DivLat-1].right;
      if (sdv_q[DivLat-1].deg) begin
        res_d[k] = '0;
      end else if (sg) begin
        res_d[k] = OutW'(-qx);
      end else if (qx > ExtW'(32767)) begin
        res_d[k] = OutW'(32767);
      end else begin
        res_d[k] = OutW'(qx);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign degenerate_o = deg_q;

  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate item with nonzero normal");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vsq_q) && $stable(vdv_q) && $stable(normal_x_o))
    else $error("pipeline moved during a stall");

endmodule
